### rtl/dc_pkg.sv
// shared types, codes, field positions and lane helpers for the data cache
`default_nettype none
package dc_pkg;

   // default geometry (both must be powers of two)
   localparam int SETS_DEF  = 128;
   localparam int WORDS_DEF = 4;

   // processor operation codes
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_STORE = 2'd2;

   // access size codes
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_BYTE = 2'd2;

   // request tdata layout
   localparam int REQ_W     = 168;
   localparam int RQ_AV     = 0;
   localparam int RQ_CA     = 1;
   localparam int RQ_SD     = 33;
   localparam int RQ_SZ     = 65;
   localparam int RQ_FULL   = 67;
   localparam int RQ_EMPTY  = 68;
   localparam int RQ_ACK    = 69;
   localparam int RQ_RA     = 70;
   localparam int RQ_RD     = 102;
   localparam int RQ_GRANT  = 134;
   localparam int RQ_SA     = 135;

   // response tdata layout
   localparam int RSP_W     = 72;
   localparam int RS_RDATA  = 0;
   localparam int RS_STALL  = 32;
   localparam int RS_PUSH   = 33;
   localparam int RS_PADDR  = 34;
   localparam int RS_BE     = 66;
   localparam int RS_MREQ   = 70;

   // refill controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_WAIT = 2'd1,
      ST_UPDT = 2'd2
   } fsm_type;

   // write controls for one way
   typedef struct packed {
      logic       data_we;
      logic [3:0] lane_en;
      logic       tag_we;
   } wr_ctl_type;

   // byte lanes touched by an access of a given size
   function automatic logic [3:0] lane_enables(input logic [1:0] size,
                                               input logic [1:0] low);
      logic [3:0] be;
      be = 4'hF;
      if (size == SZ_BYTE) begin
         be = 4'b0001 << low;
      end else if (size == SZ_HALF) begin
         be = low[1] ? 4'b1100 : 4'b0011;
      end
      return be;
   endfunction

endpackage
`default_nettype wire

### rtl/dc_ram.sv
// generic single write, single read ram with registered read
`default_nettype none
module dc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/dc_way.sv
// one cache way: byte-lane data rams, tag rams and write forwarding
`default_nettype none
module dc_way #(
   parameter int SETS  = dc_pkg::SETS_DEF,
   parameter int WORDS = dc_pkg::WORDS_DEF,
   parameter int IDX_W = $clog2(SETS),
   parameter int POS_W = $clog2(SETS) + $clog2(WORDS),
   parameter int TAG_W = 32 - $clog2(SETS) - $clog2(WORDS) - 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [POS_W-1:0]   rd_pos,
   input  wire logic [IDX_W-1:0]   rd_idx,
   input  wire logic [IDX_W-1:0]   snp_idx,
   input  wire dc_pkg::wr_ctl_type wr,
   input  wire logic [POS_W-1:0]   wr_pos,
   input  wire logic [31:0]        wr_data,
   input  wire logic [IDX_W-1:0]   wr_idx,
   input  wire logic [TAG_W-1:0]   wr_tag,
   output logic      [31:0]        rd_word,
   output logic      [TAG_W-1:0]   rd_tag,
   output logic      [TAG_W-1:0]   snp_tag
);

   localparam int DEPTH = SETS * WORDS;

   logic [31:0]      ram_word;
   logic [TAG_W-1:0] ram_tag;
   logic [TAG_W-1:0] ram_snp;
   logic [3:0]       lane_fwd_ff;
   logic             tag_fwd_ff;
   logic             snp_fwd_ff;
   logic [31:0]      fwd_data_ff;
   logic [TAG_W-1:0] fwd_tag_ff;

   // data lanes
   for (genvar i = 0; i < 4; i++) begin : g_lane
      dc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_lane (
         .clock   (clock),
         .wr_en   (wr.data_we && wr.lane_en[i]),
         .wr_addr (wr_pos),
         .wr_data (wr_data[8*i +: 8]),
         .rd_en   (rd_en),
         .rd_addr (rd_pos),
         .rd_data (ram_word[8*i +: 8])
      );
   end

   // tag copies for the processor and snoop lookups
   dc_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag_cpu (
      .clock   (clock),
      .wr_en   (wr.tag_we),
      .wr_addr (wr_idx),
      .wr_data (wr_tag),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (ram_tag)
   );

   dc_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag_snp (
      .clock   (clock),
      .wr_en   (wr.tag_we),
      .wr_addr (wr_idx),
      .wr_data (wr_tag),
      .rd_en   (rd_en),
      .rd_addr (snp_idx),
      .rd_data (ram_snp)
   );

   // capture a write landing on the edge of the read
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_fwd_ff <= '0;
         tag_fwd_ff  <= 1'b0;
         snp_fwd_ff  <= 1'b0;
      end else if (rd_en) begin
         for (int i = 0; i < 4; i++) begin
            lane_fwd_ff[i] <= wr.data_we && wr.lane_en[i] && (wr_pos == rd_pos);
         end
         tag_fwd_ff <= wr.tag_we && (wr_idx == rd_idx);
         snp_fwd_ff <= wr.tag_we && (wr_idx == snp_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr_data;
         fwd_tag_ff  <= wr_tag;
      end
   end

   // merge forwarded values
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rd_word[8*i +: 8] = lane_fwd_ff[i] ? fwd_data_ff[8*i +: 8] : ram_word[8*i +: 8];
      end
      rd_tag  = tag_fwd_ff ? fwd_tag_ff : ram_tag;
      snp_tag = snp_fwd_ff ? fwd_tag_ff : ram_snp;
   end

endmodule
`default_nettype wire

### rtl/two_way_write_through_dcache.sv
// top level of the two-way write-through data cache
//
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | req_tdata (cpu, buffer, bus fields), req_tuser (op)
// rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata (read data, stall, push, enables, request)
//
// one request a cycle while responses are taken: lookup rams are read as the request
// enters the input register, then hit test, refill controller and writes run on the
// registered request and the response register is loaded.
// reset clears valid bits, lru bits, controller state and held read data.
// a response not taken holds the input register, which then holds the request side.
`default_nettype none
module two_way_write_through_dcache #(
   parameter int SETS  = dc_pkg::SETS_DEF,
   parameter int WORDS = dc_pkg::WORDS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // addr_valid, cpu_addr, store_data, access_size, buffer_full, buffer_empty,
   // mem_ack, refill_addr, refill_data, bus_granted, snoop_addr, zero pad
   input  wire logic [dc_pkg::REQ_W-1:0]  req_tdata,
   // op
   input  wire logic [1:0]                req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // read_data, stall_res, buffer_push, push_addr, byte_enable, mem_request, zero pad
   output logic      [dc_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int IDX_W  = $clog2(SETS);
   localparam int WORD_W = $clog2(WORDS);
   localparam int OFF_W  = WORD_W + 2;
   localparam int POS_W  = IDX_W + WORD_W;
   localparam int TAG_W  = 32 - IDX_W - OFF_W;
   localparam logic [OFF_W-1:0] WORD_STEP = OFF_W'(4);

   // input register
   logic        s1_valid_ff;
   logic [1:0]  s1_op_ff;
   logic        s1_av_ff;
   logic [31:0] s1_ca_ff;
   logic [31:0] s1_sd_ff;
   logic [1:0]  s1_sz_ff;
   logic        s1_full_ff;
   logic        s1_empty_ff;
   logic        s1_ack_ff;
   logic [31:0] s1_ra_ff;
   logic [31:0] s1_rd_ff;
   logic        s1_grant_ff;
   logic [31:0] s1_sa_ff;

   // state
   dc_pkg::fsm_type   state_ff, state_in;
   logic [SETS-1:0]   valid0_ff, valid0_in;
   logic [SETS-1:0]   valid1_ff, valid1_in;
   logic [SETS-1:0]   lru_ff, lru_in;
   logic [WORD_W-1:0] burst_ff, burst_in;
   logic [OFF_W-1:0]  last_off_ff, last_off_in;
   logic [31:0]       rdata_ff, rdata_in;

   // response register
   logic        rsp_valid_ff;
   logic        stall_ff, push_ff, mreq_ff;
   logic [31:0] paddr_ff;
   logic [3:0]  be_ff;
   logic        stall_c, push_c, mreq_c;
   logic [31:0] paddr_c;
   logic [3:0]  be_c;

   logic accept, advance;

   // lookup addresses from the arriving request
   logic [31:0]      in_ca, in_sa;
   logic [POS_W-1:0] in_pos;
   logic [IDX_W-1:0] in_idx, in_sidx;

   // decoded fields of the registered request
   logic [IDX_W-1:0]  idx, sidx, ridx;
   logic [TAG_W-1:0]  tg, stg, rtg;
   logic [WORD_W-1:0] word;
   logic [OFF_W-1:0]  roff;
   logic [POS_W-1:0]  pos;
   logic [3:0]        lanes;
   logic              is_load, is_store, hit0, hit1, miss;

   // way interfaces
   dc_pkg::wr_ctl_type wr0, wr1;
   logic [POS_W-1:0]   wr_pos;
   logic [31:0]        wr_data;
   logic [IDX_W-1:0]   wr_idx;
   logic [TAG_W-1:0]   wr_tag;
   logic [31:0]        word0, word1;
   logic [TAG_W-1:0]   tag0, tag1, stag0, stag1;

   // handshake
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign in_ca   = req_tdata[dc_pkg::RQ_CA +: 32];
   assign in_sa   = req_tdata[dc_pkg::RQ_SA +: 32];
   assign in_idx  = in_ca[OFF_W +: IDX_W];
   assign in_pos  = {in_idx, in_ca[2 +: WORD_W]};
   assign in_sidx = in_sa[OFF_W +: IDX_W];

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_tuser;
         s1_av_ff    <= req_tdata[dc_pkg::RQ_AV];
         s1_ca_ff    <= in_ca;
         s1_sd_ff    <= req_tdata[dc_pkg::RQ_SD +: 32];
         s1_sz_ff    <= req_tdata[dc_pkg::RQ_SZ +: 2];
         s1_full_ff  <= req_tdata[dc_pkg::RQ_FULL];
         s1_empty_ff <= req_tdata[dc_pkg::RQ_EMPTY];
         s1_ack_ff   <= req_tdata[dc_pkg::RQ_ACK];
         s1_ra_ff    <= req_tdata[dc_pkg::RQ_RA +: 32];
         s1_rd_ff    <= req_tdata[dc_pkg::RQ_RD +: 32];
         s1_grant_ff <= req_tdata[dc_pkg::RQ_GRANT];
         s1_sa_ff    <= in_sa;
      end
   end

   // ways
   dc_way #(.SETS(SETS), .WORDS(WORDS), .IDX_W(IDX_W), .POS_W(POS_W), .TAG_W(TAG_W)) u_way0 (
      .clock (clock), .reset (reset), .rd_en (accept), .rd_pos (in_pos),
      .rd_idx (in_idx), .snp_idx (in_sidx), .wr (wr0), .wr_pos (wr_pos),
      .wr_data (wr_data), .wr_idx (wr_idx), .wr_tag (wr_tag),
      .rd_word (word0), .rd_tag (tag0), .snp_tag (stag0)
   );

   dc_way #(.SETS(SETS), .WORDS(WORDS), .IDX_W(IDX_W), .POS_W(POS_W), .TAG_W(TAG_W)) u_way1 (
      .clock (clock), .reset (reset), .rd_en (accept), .rd_pos (in_pos),
      .rd_idx (in_idx), .snp_idx (in_sidx), .wr (wr1), .wr_pos (wr_pos),
      .wr_data (wr_data), .wr_idx (wr_idx), .wr_tag (wr_tag),
      .rd_word (word1), .rd_tag (tag1), .snp_tag (stag1)
   );

   // address split and hit test
   assign idx      = s1_ca_ff[OFF_W +: IDX_W];
   assign tg       = s1_ca_ff[31 -: TAG_W];
   assign word     = s1_ca_ff[2 +: WORD_W];
   assign pos      = {idx, word};
   assign sidx     = s1_sa_ff[OFF_W +: IDX_W];
   assign stg      = s1_sa_ff[31 -: TAG_W];
   assign ridx     = s1_ra_ff[OFF_W +: IDX_W];
   assign rtg      = s1_ra_ff[31 -: TAG_W];
   assign roff     = s1_ra_ff[OFF_W-1:0];
   assign lanes    = dc_pkg::lane_enables(s1_sz_ff, s1_ca_ff[1:0]);
   assign is_load  = (s1_op_ff == dc_pkg::OP_LOAD);
   assign is_store = (s1_op_ff == dc_pkg::OP_STORE);
   assign hit0     = valid0_ff[idx] && (tag0 == tg);
   assign hit1     = valid1_ff[idx] && (tag1 == tg);
   assign miss     = !hit0 && !hit1;

   // refill controller, store path and outputs
   always_comb begin
      logic refill_we, refill_tag, store_we, store_way0;
      refill_we   = 1'b0;
      refill_tag  = 1'b0;
      store_we    = 1'b0;
      store_way0  = 1'b0;
      state_in    = dc_pkg::ST_IDLE;
      burst_in    = burst_ff;
      last_off_in = last_off_ff;
      lru_in      = lru_ff;
      valid0_in   = valid0_ff;
      valid1_in   = valid1_ff;
      rdata_in    = rdata_ff;
      mreq_c      = 1'b0;
      push_c      = 1'b0;
      paddr_c     = '0;
      be_c        = '0;
      wr0         = '0;
      wr1         = '0;
      wr_pos      = {ridx, burst_ff};
      wr_data     = s1_rd_ff;
      wr_idx      = ridx;
      wr_tag      = rtg;
      stall_c     = (is_load && miss) || (is_store && s1_full_ff);

      // load hit data
      if (is_load && hit0) begin
         rdata_in = word0;
      end else if (is_load && hit1) begin
         rdata_in = word1;
      end

      // snoop invalidation
      if (!s1_grant_ff) begin
         if (stag0 == stg) valid0_in[sidx] = 1'b0;
         if (stag1 == stg) valid1_in[sidx] = 1'b0;
      end

      unique case (state_ff)
         dc_pkg::ST_WAIT: begin
            if (s1_ack_ff) begin
               refill_we   = 1'b1;
               refill_tag  = 1'b1;
               last_off_in = roff;
               state_in    = dc_pkg::ST_UPDT;
            end else begin
               mreq_c   = 1'b1;
               burst_in = '0;
               state_in = dc_pkg::ST_WAIT;
            end
         end
         dc_pkg::ST_UPDT: begin
            if (!s1_ack_ff) begin
               lru_in[ridx] = !lru_ff[ridx];
               state_in     = dc_pkg::ST_IDLE;
            end else begin
               if (roff == last_off_ff + WORD_STEP) begin
                  last_off_in = roff;
                  refill_we   = 1'b1;
               end
               state_in = dc_pkg::ST_UPDT;
            end
         end
         default: begin
            mreq_c = !s1_empty_ff;
            push_c = ((is_load && miss) || is_store) && s1_av_ff && !s1_full_ff;
            if (is_store && s1_av_ff) begin
               store_we   = 1'b1;
               store_way0 = miss ? lru_ff[idx] : hit0;
               if (push_c) be_c = lanes;
            end else if (push_c) begin
               be_c = 4'hF;
            end
            if (push_c) paddr_c = {s1_ca_ff[31:2], 2'b00};
            if (is_load && s1_av_ff && miss && !s1_full_ff) state_in = dc_pkg::ST_WAIT;
         end
      endcase

      // refill word into the lru-selected way
      if (refill_we) begin
         burst_in = burst_ff + 1'b1;
         if (lru_ff[ridx]) begin
            wr0 = '{data_we: 1'b1, lane_en: 4'hF, tag_we: refill_tag};
            if (refill_tag) valid0_in[ridx] = 1'b1;
         end else begin
            wr1 = '{data_we: 1'b1, lane_en: 4'hF, tag_we: refill_tag};
            if (refill_tag) valid1_in[ridx] = 1'b1;
         end
      end

      // store merge into the hit or allocated way
      if (store_we) begin
         wr_pos  = pos;
         wr_data = s1_sd_ff;
         wr_idx  = idx;
         wr_tag  = tg;
         if (store_way0) begin
            wr0 = '{data_we: 1'b1, lane_en: lanes, tag_we: miss};
            if (miss) valid0_in[idx] = 1'b1;
         end else begin
            wr1 = '{data_we: 1'b1, lane_en: lanes, tag_we: miss};
            if (miss) valid1_in[idx] = 1'b1;
         end
      end

      // nothing changes unless the request completes
      if (!advance) begin
         wr0 = '0;
         wr1 = '0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dc_pkg::ST_IDLE;
         valid0_ff   <= '0;
         valid1_ff   <= '0;
         lru_ff      <= '0;
         burst_ff    <= '0;
         last_off_ff <= '0;
         rdata_ff    <= '0;
      end else if (advance) begin
         state_ff    <= state_in;
         valid0_ff   <= valid0_in;
         valid1_ff   <= valid1_in;
         lru_ff      <= lru_in;
         burst_ff    <= burst_in;
         last_off_ff <= last_off_in;
         rdata_ff    <= rdata_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stall_ff <= stall_c;
         push_ff  <= push_c;
         paddr_ff <= paddr_c;
         be_ff    <= be_c;
         mreq_ff  <= mreq_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, mreq_ff, be_ff, paddr_ff, push_ff, stall_ff, rdata_ff};

endmodule
`default_nettype wire

### sim/two_way_write_through_dcache_tb.sv
// self-checking testbench for the two-way write-through data cache
module two_way_write_through_dcache_tb;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_RSVD = 2'd3;
   localparam logic [1:0] SZ_WORD = 2'd0;
   localparam logic [1:0] SZ_RSVD = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;

   // one processor and bus cycle as seen by the cache
   typedef struct {
      logic [1:0]  op;
      logic        av;
      logic [31:0] ca;
      logic [31:0] sd;
      logic [1:0]  sz;
      logic        full;
      logic        empty;
      logic        ack;
      logic [31:0] ra;
      logic [31:0] rd;
      logic        granted;
      logic [31:0] sa;
   } access_type;

   // one response of the cache
   typedef struct {
      logic [31:0] rdata;
      logic        stall;
      logic        push;
      logic [31:0] paddr;
      logic [3:0]  be;
      logic        mreq;
   } reply_type;

   // cache state mirror, prediction and reply checking
   class dcache_scoreboard;
      logic [20:0] tag0[128];
      logic [20:0] tag1[128];
      bit          vld0[128];
      bit          vld1[128];
      logic [31:0] dat0[512];
      logic [31:0] dat1[512];
      // byte lanes of each word that a refill or store has written
      bit [3:0]    wr0[512];
      bit [3:0]    wr1[512];
      bit          lru[128];
      dc_pkg::fsm_type fsm;
      logic [1:0]  burst;
      logic [3:0]  last_off;
      logic [31:0] held;
      logic [31:0] miss_addr;
      reply_type   pending_replies[$];
      int          errors;
      int          checked;
      int          hits;
      int          refills;

      function new();
         for (int i = 0; i < 128; i++) begin
            tag0[i] = '0; tag1[i] = '0; vld0[i] = 0; vld1[i] = 0; lru[i] = 0;
         end
         for (int i = 0; i < 512; i++) begin
            dat0[i] = '0; dat1[i] = '0; wr0[i] = '0; wr1[i] = '0;
         end
         fsm = dc_pkg::ST_IDLE; burst = '0; last_off = '0; held = '0; miss_addr = '0;
         errors = 0; checked = 0; hits = 0; refills = 0;
      endfunction

      // a load hitting a word with a lane that no refill or store has written
      function bit unwritten_hit(access_type a);
         logic [6:0] ix;
         int p;
         ix = a.ca[10:4];
         p = ix * 4 + a.ca[3:2];
         if (a.op != dc_pkg::OP_LOAD) return 0;
         if (vld0[ix] && tag0[ix] == a.ca[31:11] && wr0[p] != 4'hF) return 1;
         if (vld1[ix] && tag1[ix] == a.ca[31:11] && wr1[p] != 4'hF) return 1;
         return 0;
      endfunction

      // refill word goes to the way the lru bit selects
      function void refill_word(logic [31:0] a, logic [31:0] d, bit set_tag);
         logic [6:0] ix;
         int p;
         ix = a[10:4];
         p = ix * 4 + burst;
         if (lru[ix]) begin
            dat0[p] = d; wr0[p] = 4'hF;
            if (set_tag) begin tag0[ix] = a[31:11]; vld0[ix] = 1; end
         end else begin
            dat1[p] = d; wr1[p] = 4'hF;
            if (set_tag) begin tag1[ix] = a[31:11]; vld1[ix] = 1; end
         end
         burst = burst + 2'd1;
      endfunction

      // advance the mirror by one accepted request and queue its reply
      function void predict_access(access_type a);
         reply_type r;
         logic [6:0] ix, si;
         logic [20:0] tg;
         int p;
         bit ld, st, h0, h1, miss;
         logic [31:0] m;
         logic [3:0] lw;
         dc_pkg::fsm_type nxt;
         ld = (a.op == dc_pkg::OP_LOAD); st = (a.op == dc_pkg::OP_STORE);
         ix = a.ca[10:4]; tg = a.ca[31:11]; p = ix * 4 + a.ca[3:2];
         h0 = vld0[ix] && tag0[ix] == tg;
         h1 = vld1[ix] && tag1[ix] == tg;
         miss = !h0 && !h1;
         r.stall = (ld && miss) || (st && a.full);
         r.push = 0; r.mreq = 0; r.paddr = '0; r.be = '0;
         nxt = dc_pkg::ST_IDLE;
         if (ld && h0) begin held = dat0[p]; hits++; end
         else if (ld && h1) begin held = dat1[p]; hits++; end
         // snoop invalidation while the bus belongs to someone else
         if (!a.granted) begin
            si = a.sa[10:4];
            if (tag0[si] == a.sa[31:11]) vld0[si] = 0;
            if (tag1[si] == a.sa[31:11]) vld1[si] = 0;
         end
         case (fsm)
            dc_pkg::ST_WAIT: begin
               if (a.ack) begin
                  refill_word(a.ra, a.rd, 1);
                  last_off = a.ra[3:0];
                  nxt = dc_pkg::ST_UPDT;
               end else begin
                  r.mreq = 1; burst = '0; nxt = dc_pkg::ST_WAIT;
               end
            end
            dc_pkg::ST_UPDT: begin
               if (!a.ack) begin
                  lru[a.ra[10:4]] = !lru[a.ra[10:4]];
                  refills++;
               end else begin
                  if (a.ra[3:0] == last_off + 4'd4) begin
                     last_off = a.ra[3:0];
                     refill_word(a.ra, a.rd, 0);
                  end
                  nxt = dc_pkg::ST_UPDT;
               end
            end
            default: begin
               r.mreq = !a.empty;
               r.push = ((ld && miss) || st) && a.av && !a.full;
               if (st && a.av) begin
                  if (a.sz == dc_pkg::SZ_BYTE) m = 32'hFF << (8 * a.ca[1:0]);
                  else if (a.sz == dc_pkg::SZ_HALF) m = a.ca[1] ? 32'hFFFF0000 : 32'h0000FFFF;
                  else m = 32'hFFFFFFFF;
                  for (int i = 0; i < 4; i++) lw[i] = |m[8*i +: 8];
                  if ((miss && lru[ix]) || (!miss && h0)) begin
                     if (miss) begin tag0[ix] = tg; vld0[ix] = 1; end
                     dat0[p] = (dat0[p] & ~m) | (a.sd & m); wr0[p] = wr0[p] | lw;
                  end else begin
                     if (miss) begin tag1[ix] = tg; vld1[ix] = 1; end
                     dat1[p] = (dat1[p] & ~m) | (a.sd & m); wr1[p] = wr1[p] | lw;
                  end
                  if (r.push) r.be = lw;
               end else if (r.push) begin
                  r.be = 4'hF;
               end
               if (r.push) r.paddr = {a.ca[31:2], 2'b00};
               if (ld && a.av && miss && !a.full) begin
                  nxt = dc_pkg::ST_WAIT; miss_addr = a.ca;
               end
            end
         endcase
         fsm = nxt;
         r.rdata = held;
         pending_replies.push_back(r);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("reply %0d: %s is %h, want %h", checked, what, got, want);
         errors++;
      endtask

      // compare one accepted reply with the oldest prediction
      task check_reply(logic [dc_pkg::RSP_W-1:0] t);
         reply_type w;
         checked++;
         if (pending_replies.size() == 0) begin
            $display("reply %0d: no request outstanding", checked);
            errors++;
         end else begin
            w = pending_replies.pop_front();
            if (t[dc_pkg::RS_RDATA +: 32] !== w.rdata)
               report("read_data", t[dc_pkg::RS_RDATA +: 32], w.rdata);
            if (t[dc_pkg::RS_STALL] !== w.stall)
               report("stall_res", 32'(t[dc_pkg::RS_STALL]), 32'(w.stall));
            if (t[dc_pkg::RS_PUSH] !== w.push)
               report("buffer_push", 32'(t[dc_pkg::RS_PUSH]), 32'(w.push));
            if (t[dc_pkg::RS_PADDR +: 32] !== w.paddr)
               report("push_addr", t[dc_pkg::RS_PADDR +: 32], w.paddr);
            if (t[dc_pkg::RS_BE +: 4] !== w.be)
               report("byte_enable", 32'(t[dc_pkg::RS_BE +: 4]), 32'(w.be));
            if (t[dc_pkg::RS_MREQ] !== w.mreq)
               report("mem_request", 32'(t[dc_pkg::RS_MREQ]), 32'(w.mreq));
         end
      endtask
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [dc_pkg::REQ_W-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic [dc_pkg::RSP_W-1:0] rsp_tdata;
   int send_idle_pct, recv_stall_pct, cycles;
   dcache_scoreboard sb;

   two_way_write_through_dcache u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // run length guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycles);
         $display("two_way_write_through_dcache: mismatch");
         $finish;
      end
   end

   // reply side: check accepted replies and stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_reply(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic access_type mk(logic [1:0] op, logic [31:0] ca, logic [31:0] sd,
                                     logic [1:0] sz);
      access_type a;
      a.op = op; a.av = 1; a.ca = ca; a.sd = sd; a.sz = sz;
      a.full = 0; a.empty = 1; a.ack = 0; a.ra = '0; a.rd = '0;
      a.granted = 1; a.sa = '0;
      return a;
   endfunction

   // addresses from a few tags and sets so that lines get reused
   function automatic logic [31:0] pool_addr();
      logic [31:0] a;
      if ($urandom_range(19) == 0) return $urandom;
      a = $urandom;
      a[31:11] = ($urandom_range(9) == 0) ? a[31:11] : 21'($urandom_range(2));
      a[10:4] = ($urandom_range(9) == 0) ? a[10:4] : 7'($urandom_range(3));
      return a;
   endfunction

   // random request shaped by where the refill controller stands
   function automatic access_type random_access();
      access_type a;
      int r;
      r = $urandom_range(99);
      a.op = (r < 40) ? dc_pkg::OP_LOAD : (r < 75) ? dc_pkg::OP_STORE :
             (r < 90) ? OP_NONE : OP_RSVD;
      a.av = ($urandom_range(9) != 0);
      a.ca = pool_addr();
      a.sd = $urandom;
      a.sz = 2'($urandom_range(3));
      a.full = ($urandom_range(6) == 0);
      a.empty = 1'($urandom_range(1));
      a.granted = ($urandom_range(6) != 0);
      a.sa = pool_addr();
      a.rd = $urandom;
      a.ra = {sb.miss_addr[31:4], 4'h0};
      a.ack = 0;
      if (sb.fsm == dc_pkg::ST_WAIT) begin
         a.ack = ($urandom_range(9) < 6);
      end else if (sb.fsm == dc_pkg::ST_UPDT) begin
         a.ack = ($urandom_range(9) < 8);
         a.ra[3:0] = sb.last_off + 4'd4;
      end else begin
         a.ack = ($urandom_range(9) == 0);
      end
      if ($urandom_range(14) == 0) a.ra = $urandom;
      return a;
   endfunction

   // present one request and wait for it to be taken
   task send(access_type a);
      if (sb.unwritten_hit(a)) a.op = dc_pkg::OP_STORE;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= a.op;
      req_tdata <= {1'b0, a.sa, a.granted, a.rd, a.ra, a.ack, a.empty, a.full,
                    a.sz, a.sd, a.ca, a.av};
      do @(posedge clock); while (!req_tready);
      sb.predict_access(a);
   endtask

   task drain();
      req_tvalid <= 0;
      while (sb.pending_replies.size() != 0) @(posedge clock);
   endtask

   initial begin
      access_type a;
      cycles = 0;
      sb = new();
      reset = 1; req_tvalid = 0; req_tdata = '0; req_tuser = OP_NONE; rsp_tready = 0;
      send_idle_pct = 25; recv_stall_pct = 54;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: stores of each size, loads, refill burst, snoop, full buffer
      send(mk(dc_pkg::OP_STORE, 32'h0000_0000, 32'hFFFF_FFFF, SZ_WORD));
      send(mk(dc_pkg::OP_LOAD, 32'h0000_0000, 32'h0, SZ_WORD));
      for (int i = 0; i < 4; i++)
         send(mk(dc_pkg::OP_STORE, 32'(i), 32'h1234_5678, dc_pkg::SZ_BYTE));
      send(mk(dc_pkg::OP_STORE, 32'h0000_0002, 32'hABCD_0000, dc_pkg::SZ_HALF));
      send(mk(dc_pkg::OP_STORE, 32'h0000_0001, 32'h0000_5A5A, dc_pkg::SZ_HALF));
      send(mk(dc_pkg::OP_STORE, 32'hFFFF_FFFF, 32'h8765_4321, SZ_RSVD));
      send(mk(OP_RSVD, 32'hFFFF_FFFC, 32'h0, SZ_WORD));
      a = mk(dc_pkg::OP_STORE, 32'h0000_0004, 32'hCAFE_F00D, SZ_WORD); a.full = 1; send(a);
      a = mk(dc_pkg::OP_LOAD, 32'h0000_8010, 32'h0, SZ_WORD); a.full = 1; a.empty = 0;
      send(a);
      send(mk(dc_pkg::OP_LOAD, 32'h0000_8010, 32'h0, SZ_WORD));
      send(mk(OP_NONE, 32'h0, 32'h0, SZ_WORD));
      for (int i = 0; i < 4; i++) begin
         a = mk(dc_pkg::OP_STORE, 32'h0000_8010, 32'h0, SZ_WORD); a.ack = 1;
         a.ra = 32'h0000_8010 + 32'(4 * i); a.rd = 32'(32'h1111_1111 * (i + 1)); send(a);
      end
      a = mk(OP_NONE, 32'h0, 32'h0, SZ_WORD); a.ra = 32'h0000_8010; send(a);
      for (int i = 0; i < 4; i++)
         send(mk(dc_pkg::OP_LOAD, 32'h0000_8010 + 32'(4 * i), 32'h0, SZ_WORD));
      a = mk(dc_pkg::OP_LOAD, 32'h0000_0000, 32'h0, SZ_WORD); a.granted = 0;
      a.sa = 32'h0000_0000;
      send(a);
      send(mk(dc_pkg::OP_LOAD, 32'h0000_0000, 32'h0, SZ_WORD));
      drain();

      // random traffic in three idling phases, each with a full drain midway through
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 54 : 0;
         recv_stall_pct = (ph == 0) ? 54 : (ph == 1) ? 25 : 0;
         for (int n = 0; n < 560; n++) begin
            send(random_access());
            if (n == 280) drain();
         end
      end
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d replies, %0d load hits, %0d refill bursts completed",
               sb.checked, sb.hits, sb.refills);
      if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
         $display("two_way_write_through_dcache: match");
      end else begin
         $display("%0d errors, %0d replies missing", sb.errors, sb.pending_replies.size());
         $display("two_way_write_through_dcache: mismatch");
      end
      $finish;
   end

endmodule
